// ----- rtl/voxel_occupancy_grid_top_macros.svh -----
// Assertion macros shared by the voxel occupancy grid RTL.
`ifndef VOXEL_OCCUPANCY_GRID_TOP_MACROS_SVH
`define VOXEL_OCCUPANCY_GRID_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define VOXOG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define VOXOG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/voxog_pkg.sv -----
// Shared types, constants and helpers of the voxel occupancy grid.
package voxog_pkg;

  localparam int MAX_X_DEF = 64;
  localparam int MAX_Y_DEF = 64;
  localparam int MAX_Z_DEF = 64;

  localparam int COORD_W  = 24;
  localparam int INV_W    = 24;
  localparam int SIZE_W   = 7;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [COORD_W-1:0] ORIGIN_RST  = '0;
  localparam logic        [INV_W-1:0]   INV_RES_RST = 24'd65536;
  localparam logic        [SIZE_W-1:0]  SIZE_RST    = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X = 3'd0,
    REG_ORIGIN_Y = 3'd1,
    REG_ORIGIN_Z = 3'd2,
    REG_INV_RES  = 3'd3,
    REG_SIZE_X   = 3'd4,
    REG_SIZE_Y   = 3'd5,
    REG_SIZE_Z   = 3'd6
  } voxog_reg_e;

  typedef enum logic {
    FUNC_MARK  = 1'b0,
    FUNC_QUERY = 1'b1
  } voxog_func_e;

  // Bits needed to index n entries, never less than one.
  function automatic int idx_width(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ----- rtl/voxog_axis.sv -----
// Per-axis voxel index unit: registered scaling product, then floor, range test and clamp.
module voxog_axis #(
  parameter int MAX = voxog_pkg::MAX_X_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    load_i,
  input  logic signed [voxog_pkg::COORD_W-1:0]    coord_i,
  input  logic signed [voxog_pkg::COORD_W-1:0]    origin_i,
  input  logic        [voxog_pkg::INV_W-1:0]      inv_res_i,
  input  logic        [voxog_pkg::SIZE_W-1:0]     size_i,
  output logic        [voxog_pkg::idx_width(MAX)-1:0] idx_o,
  output logic                                    inside_o
);

  localparam int IW = voxog_pkg::idx_width(MAX);
  localparam int CW = voxog_pkg::COORD_W;
  localparam int PW = CW + voxog_pkg::INV_W;
  localparam logic [CW-1:0] MAX_V = CW'(MAX);

  logic [CW:0]   diff;
  logic [PW-1:0] prod_q;
  logic          neg_q;
  logic [CW-1:0] raw;
  logic [CW-1:0] size_w;
  logic [CW-1:0] size_eff;
  logic          below_size;

  assign diff = {coord_i[CW-1], coord_i} - {origin_i[CW-1], origin_i};

  // A negative offset only counts as negative when the scale is nonzero;
  // with a zero scale the product is zero and the index lands on 0.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      neg_q  <= diff[CW] && (inv_res_i != '0);
      prod_q <= diff[CW-1:0] * inv_res_i;
    end
  end

  assign raw    = prod_q[PW-1:CW];
  assign size_w = {{(CW - voxog_pkg::SIZE_W){1'b0}}, size_i};

  always_comb begin
    if (size_i == '0) begin
      size_eff = CW'(1);
    end else if (size_w > MAX_V) begin
      size_eff = MAX_V;
    end else begin
      size_eff = size_w;
    end
  end

  assign below_size = raw < size_eff;
  assign inside_o   = !neg_q && below_size;

  always_comb begin
    if (neg_q) begin
      idx_o = '0;
    end else if (below_size) begin
      idx_o = raw[IW-1:0];
    end else begin
      idx_o = IW'(size_eff - CW'(1));
    end
  end

endmodule

// ----- rtl/voxog_mem.sv -----
// Row-organized occupancy memory with a clearing sweep after reset.
module voxog_mem #(
  parameter int ROWS  = voxog_pkg::MAX_X_DEF * voxog_pkg::MAX_Y_DEF,
  parameter int WIDTH = voxog_pkg::MAX_Z_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   rd_en_i,
  input  logic [voxog_pkg::idx_width(ROWS)-1:0]  rd_addr_i,
  output logic [WIDTH-1:0]                       rd_data_o,
  input  logic                                   wr_en_i,
  input  logic [voxog_pkg::idx_width(ROWS)-1:0]  wr_addr_i,
  input  logic [WIDTH-1:0]                       wr_data_i,
  output logic                                   clearing_o
);

  localparam int AW = voxog_pkg::idx_width(ROWS);
  localparam logic [AW-1:0] LAST_ROW = AW'(ROWS - 1);

  logic [WIDTH-1:0] mem [ROWS];
  logic [WIDTH-1:0] rd_data_q;
  logic [AW-1:0]    clr_addr_q;
  logic [AW-1:0]    clr_addr_d;
  logic             clearing_q;
  logic             clearing_d;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [WIDTH-1:0] wdata;

  always_comb begin
    clr_addr_d = clr_addr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      clr_addr_d = clr_addr_q + AW'(1);
      if (clr_addr_q == LAST_ROW) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_addr_q <= clr_addr_d;
    end
  end

  // The sweep owns the write port until every row is zero.
  assign we    = clearing_q || wr_en_i;
  assign waddr = clearing_q ? clr_addr_q : wr_addr_i;
  assign wdata = clearing_q ? '0 : wr_data_i;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o  = rd_data_q;
  assign clearing_o = clearing_q;

endmodule

// ----- rtl/voxel_occupancy_grid_top.sv -----
// Top level of the voxel occupancy grid: configuration, item sequencer and result register.
// Usage:
// Items enter on in_valid_i/in_ready_o with func_i and a signed Q16.8 point
// (coord_x_i, coord_y_i, coord_z_i). A mark sets the voxel when the point lies
// inside the grid; a query reports whether the clamped voxel is free.
// Each word yields one result word on out_valid_o/out_ready_i carrying
// is_free_o and marked_o.
// Registers are written on cfg_valid_i/cfg_ready_o with cfg_index_i and
// cfg_data_i; cfg_ready_o is always high. Write them only while idle.
// Sequence: one item at a time through operand capture, scaling multiply,
// index clamp, row read and row write-back on the occupancy memory, which
// has separate read and write ports; the next word is taken only after
// write-back.
// Reset: the configuration, state and result registers take their reset
// values and the memory is swept to zero one row per cycle over all
// MAX_X*MAX_Y rows (4096 at the defaults); in_ready_o stays low during the sweep.
// Stall: a finished result waits in the output register; the next word may
// be accepted and worked on, and it holds at write-back until the slot frees.
module voxel_occupancy_grid_top #(
  parameter int MAX_X = voxog_pkg::MAX_X_DEF,
  parameter int MAX_Y = voxog_pkg::MAX_Y_DEF,
  parameter int MAX_Z = voxog_pkg::MAX_Z_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 func_i,
  input  logic signed [voxog_pkg::COORD_W-1:0] coord_x_i,
  input  logic signed [voxog_pkg::COORD_W-1:0] coord_y_i,
  input  logic signed [voxog_pkg::COORD_W-1:0] coord_z_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 is_free_o,
  output logic                                 marked_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [voxog_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [voxog_pkg::COORD_W-1:0]        cfg_data_i
);

  `include "voxel_occupancy_grid_top_macros.svh"

  localparam int CW   = voxog_pkg::COORD_W;
  localparam int XW   = voxog_pkg::idx_width(MAX_X);
  localparam int YW   = voxog_pkg::idx_width(MAX_Y);
  localparam int ZW   = voxog_pkg::idx_width(MAX_Z);
  localparam int ROWS = MAX_X * MAX_Y;
  localparam int RW   = voxog_pkg::idx_width(ROWS);
  localparam logic [RW-1:0] MAX_Y_R = RW'(MAX_Y);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADDR,
    ST_READ,
    ST_WRITE
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic signed [CW-1:0]                 origin_x_q, origin_y_q, origin_z_q;
  logic [voxog_pkg::INV_W-1:0]          inv_res_q;
  logic [voxog_pkg::SIZE_W-1:0]         size_x_q, size_y_q, size_z_q;

  // Item payload.
  voxog_pkg::voxog_func_e               func_q;
  logic signed [CW-1:0]                 coord_x_q, coord_y_q, coord_z_q;
  logic [XW-1:0]                        idx_x, idx_x_q;
  logic [YW-1:0]                        idx_y, idx_y_q;
  logic [ZW-1:0]                        idx_z, idx_z_q;
  logic                                 in_x, in_y, in_z;
  logic                                 inside_q;
  logic [RW-1:0]                        row_d, row_q;

  logic                                 out_valid_q, out_valid_d;
  logic                                 is_free_q, is_free_d;
  logic                                 marked_q, marked_d;

  logic                                 in_acc;
  logic                                 advance;
  logic                                 clearing;
  logic                                 mem_rd_en;
  logic                                 mem_wr_en;
  logic [MAX_Z-1:0]                     rd_row;
  logic [MAX_Z-1:0]                     wr_row;
  logic                                 axis_load;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q <= voxog_pkg::ORIGIN_RST;
      origin_y_q <= voxog_pkg::ORIGIN_RST;
      origin_z_q <= voxog_pkg::ORIGIN_RST;
      inv_res_q  <= voxog_pkg::INV_RES_RST;
      size_x_q   <= voxog_pkg::SIZE_RST;
      size_y_q   <= voxog_pkg::SIZE_RST;
      size_z_q   <= voxog_pkg::SIZE_RST;
    end else if (cfg_valid_i) begin
      unique case (voxog_pkg::voxog_reg_e'(cfg_index_i))
        voxog_pkg::REG_ORIGIN_X: origin_x_q <= cfg_data_i;
        voxog_pkg::REG_ORIGIN_Y: origin_y_q <= cfg_data_i;
        voxog_pkg::REG_ORIGIN_Z: origin_z_q <= cfg_data_i;
        voxog_pkg::REG_INV_RES:  inv_res_q  <= cfg_data_i;
        voxog_pkg::REG_SIZE_X:   size_x_q   <= cfg_data_i[voxog_pkg::SIZE_W-1:0];
        voxog_pkg::REG_SIZE_Y:   size_y_q   <= cfg_data_i[voxog_pkg::SIZE_W-1:0];
        voxog_pkg::REG_SIZE_Z:   size_z_q   <= cfg_data_i[voxog_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = (state_q == ST_IDLE) && !clearing;
  assign in_acc     = in_valid_i && in_ready_o;
  assign advance    = !out_valid_q || out_ready_i;
  assign axis_load  = (state_q == ST_MUL);

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q    <= voxog_pkg::voxog_func_e'(func_i);
      coord_x_q <= coord_x_i;
      coord_y_q <= coord_y_i;
      coord_z_q <= coord_z_i;
    end
    if (state_q == ST_ADDR) begin
      idx_x_q  <= idx_x;
      idx_y_q  <= idx_y;
      idx_z_q  <= idx_z;
      inside_q <= in_x && in_y && in_z;
    end
    if (state_q == ST_READ) begin
      row_q <= row_d;
    end
  end

  voxog_axis #(.MAX(MAX_X)) u_axis_x (
    .clk_i     (clk_i),
    .load_i    (axis_load),
    .coord_i   (coord_x_q),
    .origin_i  (origin_x_q),
    .inv_res_i (inv_res_q),
    .size_i    (size_x_q),
    .idx_o     (idx_x),
    .inside_o  (in_x)
  );

  voxog_axis #(.MAX(MAX_Y)) u_axis_y (
    .clk_i     (clk_i),
    .load_i    (axis_load),
    .coord_i   (coord_y_q),
    .origin_i  (origin_y_q),
    .inv_res_i (inv_res_q),
    .size_i    (size_y_q),
    .idx_o     (idx_y),
    .inside_o  (in_y)
  );

  voxog_axis #(.MAX(MAX_Z)) u_axis_z (
    .clk_i     (clk_i),
    .load_i    (axis_load),
    .coord_i   (coord_z_q),
    .origin_i  (origin_z_q),
    .inv_res_i (inv_res_q),
    .size_i    (size_z_q),
    .idx_o     (idx_z),
    .inside_o  (in_z)
  );

  // One memory row holds the whole z column of an (x, y) pair.
  assign row_d = RW'(idx_x_q) * MAX_Y_R + RW'(idx_y_q);

  assign mem_rd_en = (state_q == ST_READ);
  assign mem_wr_en = (state_q == ST_WRITE) && advance &&
                     (func_q == voxog_pkg::FUNC_MARK) && inside_q;

  always_comb begin
    wr_row          = rd_row;
    wr_row[idx_z_q] = 1'b1;
  end

  voxog_mem #(.ROWS(ROWS), .WIDTH(MAX_Z)) u_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (mem_rd_en),
    .rd_addr_i  (row_d),
    .rd_data_o  (rd_row),
    .wr_en_i    (mem_wr_en),
    .wr_addr_i  (row_q),
    .wr_data_i  (wr_row),
    .clearing_o (clearing)
  );

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    is_free_d   = is_free_q;
    marked_d    = marked_q;
    unique case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_MUL;
      ST_MUL:   state_d = ST_ADDR;
      ST_ADDR:  state_d = ST_READ;
      ST_READ:  state_d = ST_WRITE;
      ST_WRITE: begin
        if (advance) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          if (func_q == voxog_pkg::FUNC_MARK) begin
            is_free_d = 1'b0;
            marked_d  = inside_q;
          end else begin
            is_free_d = !rd_row[idx_z_q];
            marked_d  = 1'b0;
          end
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      is_free_q   <= 1'b0;
      marked_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      is_free_q   <= is_free_d;
      marked_q    <= marked_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_free_o   = is_free_q;
  assign marked_o    = marked_q;

  `VOXOG_ASSERT_NOW(a_no_accept_clearing, clearing, !in_ready_o, "input taken during clear sweep")
  `VOXOG_ASSERT_NEXT(a_one_in_flight, in_acc, !in_ready_o, "second word taken while one is in work")
  `VOXOG_ASSERT_NOW(a_mark_not_free, out_valid_o && marked_o, !is_free_o, "mark result reports free")
  `VOXOG_ASSERT_NEXT(a_wb_to_out, (state_q == ST_WRITE) && advance, out_valid_o && in_ready_o,
                     "write-back did not post a result")
  `VOXOG_ASSERT_NOW(a_no_wr_clearing, mem_wr_en, !clearing, "item write during clear sweep")

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the voxel occupancy grid: directed corners, then random traffic.
`timescale 1ns / 100ps

module tb_top;
  import voxog_pkg::*;

  localparam int GRID_X = MAX_X_DEF;
  localparam int GRID_Y = MAX_Y_DEF;
  localparam int GRID_Z = MAX_Z_DEF;
  localparam int CELLS  = GRID_X * GRID_Y * GRID_Z;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
  localparam logic [INV_W-1:0]          INV_MAX   = 24'hFFFFFF;

  // No word moves during the clearing sweep after reset.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int LONG_HOLD      = 160;
  localparam int DRAIN_CYCLES   = 20;
  localparam int RECENT_DEPTH   = 64;

  typedef struct packed {
    logic is_free;
    logic marked;
  } voxel_reply_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic                      func_i      = FUNC_MARK;
  logic signed [COORD_W-1:0] coord_x_i   = '0;
  logic signed [COORD_W-1:0] coord_y_i   = '0;
  logic signed [COORD_W-1:0] coord_z_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic                      is_free_o;
  logic                      marked_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i = '0;
  logic [COORD_W-1:0]        cfg_data_i  = '0;

  // Predictor state: the occupancy map and the register file as the block should hold them.
  bit                        occ_map [CELLS];
  logic signed [COORD_W-1:0] grid_origin [3];
  logic [INV_W-1:0]          grid_inv_res;
  logic [SIZE_W-1:0]         grid_size [3];

  voxel_reply_t reply_q [$];
  point_t       recent_pts [$];
  int           n_errors      = 0;
  int           stuck_cycles  = 0;
  bit           idle_en       = 1'b1;
  bit           long_hold_req = 1'b0;

  voxel_occupancy_grid_top #(
    .MAX_X(GRID_X),
    .MAX_Y(GRID_Y),
    .MAX_Z(GRID_Z)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .func_i     (func_i),
    .coord_x_i  (coord_x_i),
    .coord_y_i  (coord_y_i),
    .coord_z_i  (coord_z_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .is_free_o  (is_free_o),
    .marked_o   (marked_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned eff_size(input int axis);
    int unsigned lim;
    lim = (axis == 0) ? GRID_X : (axis == 1) ? GRID_Y : GRID_Z;
    if (grid_size[axis] == 0) return 1;
    if (grid_size[axis] > lim) return lim;
    return grid_size[axis];
  endfunction

  // Floors (coord - origin) * inv_res / 2^24 exactly; in_rng is low when the raw index left [0, size).
  task automatic axis_voxel(input int axis, input logic signed [COORD_W-1:0] coord,
                            output int unsigned idx, output bit in_rng);
    longint          diff;
    longint unsigned prod;
    int unsigned     lim;
    lim  = eff_size(axis);
    diff = longint'(coord) - longint'(grid_origin[axis]);
    if (diff < 0) begin
      idx    = 0;
      in_rng = (grid_inv_res == 0);
    end else begin
      prod = (longint'(unsigned'(diff)) * longint'(grid_inv_res)) >> 24;
      if (prod >= lim) begin
        idx    = lim - 1;
        in_rng = 1'b0;
      end else begin
        idx    = int'(prod);
        in_rng = 1'b1;
      end
    end
  endtask

  task automatic predict_item(input voxog_func_e f, input point_t p);
    int unsigned  ix, iy, iz, addr;
    bit           okx, oky, okz, in_grid;
    voxel_reply_t r;
    axis_voxel(0, p.x, ix, okx);
    axis_voxel(1, p.y, iy, oky);
    axis_voxel(2, p.z, iz, okz);
    in_grid = okx && oky && okz;
    addr    = (ix * GRID_Y + iy) * GRID_Z + iz;
    if (f == FUNC_MARK) begin
      if (in_grid) occ_map[addr] = 1'b1;
      r.is_free = 1'b0;
      r.marked  = in_grid;
    end else begin
      r.is_free = !occ_map[addr];
      r.marked  = 1'b0;
    end
    reply_q.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic point_t pt(input logic signed [COORD_W-1:0] x, y, z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    return p;
  endfunction

  // Leaves valid high so that a following word goes out back to back.
  task automatic send_item(input voxog_func_e f, input point_t p);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    func_i     <= f;
    coord_x_i  <= p.x;
    coord_y_i  <= p.y;
    coord_z_i  <= p.z;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(f, p);
    recent_pts.push_back(p);
    if (recent_pts.size() > RECENT_DEPTH) void'(recent_pts.pop_front());
  endtask

  task automatic end_burst();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic in_gap();
    if (idle_en && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 10)) @(negedge clk_i);
    end
  endtask

  task automatic wait_drained();
    while (reply_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z: grid_origin[idx] = data;
      REG_INV_RES: grid_inv_res = data;
      REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z: grid_size[idx - REG_SIZE_X] = data[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_release();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_grid(input logic [COORD_W-1:0] ox, oy, oz, inv, sx, sy, sz);
    write_reg(REG_ORIGIN_X, ox);
    write_reg(REG_ORIGIN_Y, oy);
    write_reg(REG_ORIGIN_Z, oz);
    write_reg(REG_INV_RES, inv);
    write_reg(REG_SIZE_X, sx);
    write_reg(REG_SIZE_Y, sy);
    write_reg(REG_SIZE_Z, sz);
    cfg_release();
  endtask

  // A coordinate around the grid on one axis, often right at its lower or upper edge.
  function automatic logic signed [COORD_W-1:0] near_coord(input int axis);
    longint span, off, c;
    if (grid_inv_res == 0) span = 256;
    else span = (longint'(eff_size(axis)) << 24) / longint'(grid_inv_res);
    if (span > 64'sd16777216) span = 16777216;
    case ($urandom_range(0, 3))
      0:       off = longint'($urandom_range(0, 6)) - 3;
      1:       off = span + longint'($urandom_range(0, 6)) - 3;
      default: off = longint'($urandom_range(0, span + span / 4 + 8)) - span / 8 - 4;
    endcase
    c = longint'(grid_origin[axis]) + off;
    if (c < longint'(COORD_MIN)) c = COORD_MIN;
    if (c > longint'(COORD_MAX)) c = COORD_MAX;
    return c[COORD_W-1:0];
  endfunction

  // Mostly points around the grid and revisits of recent points, with some raw noise.
  task automatic send_random(input int n_items);
    point_t      p;
    voxog_func_e f;
    int          kind;
    int          i;
    for (i = 0; i < n_items; i++) begin
      kind = $urandom_range(0, 99);
      f    = voxog_func_e'($urandom_range(0, 1));
      if (kind < 10) begin
        p = pt(COORD_W'($urandom()), COORD_W'($urandom()), COORD_W'($urandom()));
      end else if (kind < 40 && recent_pts.size() > 0) begin
        p = recent_pts[$urandom_range(0, recent_pts.size() - 1)];
        f = ($urandom_range(0, 3) == 0) ? FUNC_MARK : FUNC_QUERY;
      end else begin
        p = pt(near_coord(0), near_coord(1), near_coord(2));
      end
      in_gap();
      send_item(f, p);
    end
    end_burst();
    wait_drained();
  endtask

  function automatic logic [COORD_W-1:0] size_word(input int unsigned sz);
    return (COORD_W'($urandom()) & 24'hFFFF80) | COORD_W'(sz);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_default_grid();
    send_item(FUNC_MARK, pt(0, 0, 0));
    send_item(FUNC_QUERY, pt(0, 0, 0));
    send_item(FUNC_QUERY, pt(24'h100, 0, 0));
    send_item(FUNC_MARK, pt(24'h3FFF, 24'h3FFF, 24'h3FFF));
    send_item(FUNC_MARK, pt(24'h4000, 0, 0));
    send_item(FUNC_QUERY, pt(COORD_MAX, COORD_MAX, COORD_MAX));
    send_item(FUNC_MARK, pt(-1, 0, 0));
    send_item(FUNC_QUERY, pt(COORD_MIN, COORD_MIN, COORD_MIN));
    send_item(FUNC_MARK, pt(COORD_MAX, 0, 0));
    end_burst();
    wait_drained();
  endtask

  task automatic test_register_corners();
    // A write to an unmapped index must leave the grid as it was.
    write_reg(REG_UNMAPPED, 24'hFFFFFF);
    cfg_release();
    send_item(FUNC_QUERY, pt(0, 0, 0));
    end_burst();
    wait_drained();

    // Size zero acts as one, and sizes above the maximum act as the maximum.
    set_grid(0, 0, 0, 24'd65536, 24'd0, 24'd127, 24'hFFFF85);
    send_item(FUNC_MARK, pt(24'h0FF, 24'h3F00, 24'h480));
    send_item(FUNC_MARK, pt(24'h100, 0, 0));
    send_item(FUNC_QUERY, pt(24'h100, 24'h3F00, 24'h480));
    send_item(FUNC_QUERY, pt(0, COORD_MAX, COORD_MAX));
    end_burst();
    wait_drained();

    // With a zero inverse resolution every point lands in voxel zero, even below origin.
    set_grid(0, 0, 0, 24'd0, 24'd64, 24'd64, 24'd64);
    send_item(FUNC_MARK, pt(COORD_MIN, COORD_MAX, -5));
    send_item(FUNC_QUERY, pt(24'h123456, -24'sd77, 24'h000ABC));
    end_burst();
    wait_drained();

    set_grid(COORD_MIN, COORD_MIN, COORD_MIN, INV_MAX, 24'd64, 24'd64, 24'd64);
    send_item(FUNC_MARK, pt(24'sh800040, 24'sh800040, 24'sh800040));
    send_item(FUNC_MARK, pt(COORD_MAX, COORD_MIN, 24'sh800001));
    send_item(FUNC_QUERY, pt(24'sh800040, 24'sh800040, 24'sh800040));
    end_burst();
    wait_drained();

    set_grid(COORD_MAX, COORD_MAX, COORD_MAX, 24'd1, 24'd64, 24'd64, 24'd64);
    send_item(FUNC_MARK, pt(COORD_MAX, COORD_MAX, COORD_MAX));
    send_item(FUNC_QUERY, pt(0, 0, 0));
    send_item(FUNC_MARK, pt(0, 0, 0));
    end_burst();
    wait_drained();
  endtask

  task automatic test_random_default();
    set_grid(0, 0, 0, INV_RES_RST, SIZE_RST, SIZE_RST, SIZE_RST);
    idle_en = 1'b1;
    send_random(200);
  endtask

  task automatic test_small_grids();
    int k;
    for (k = 0; k < 3; k++) begin
      set_grid(COORD_W'($urandom_range(0, 8192) - 4096), COORD_W'($urandom_range(0, 8192) - 4096),
               COORD_W'($urandom_range(0, 8192) - 4096),
               ($urandom_range(0, 1) == 0) ? 24'd65536 : 24'd262144,
               size_word($urandom_range(1, 6)), size_word($urandom_range(1, 6)),
               size_word($urandom_range(1, 6)));
      send_random(50);
    end
  endtask

  task automatic test_random_grids();
    logic [COORD_W-1:0] org [3];
    logic [INV_W-1:0]   inv;
    int unsigned        sz [3];
    int                 k, a;
    for (k = 0; k < 6; k++) begin
      for (a = 0; a < 3; a++) begin
        org[a] = ($urandom_range(0, 2) == 0) ? COORD_W'($urandom())
                                             : COORD_W'($urandom_range(0, 16384) - 8192);
        sz[a]  = ($urandom_range(0, 5) == 0) ? $urandom_range(65, 127) : $urandom_range(1, 64);
      end
      case ($urandom_range(0, 2))
        0:       inv = INV_W'($urandom_range(1, INV_MAX));
        1:       inv = INV_W'($urandom_range(24'h001000, 24'h100000));
        default: inv = INV_W'(24'd65536 << $urandom_range(0, 7));
      endcase
      set_grid(org[0], org[1], org[2], inv, size_word(sz[0]), size_word(sz[1]),
               size_word(sz[2]));
      idle_en = $urandom_range(0, 1);
      send_random(50);
    end
  endtask

  // The receiver stops for a long stretch while words keep coming, so the input backs up.
  task automatic test_output_stall();
    set_grid(0, 0, 0, INV_RES_RST, 24'd8, 24'd8, 24'd8);
    idle_en       = 1'b0;
    long_hold_req = 1'b1;
    send_random(40);
  endtask

  task automatic test_steady_stream();
    set_grid(24'hFFFF00, 0, 24'h000100, 24'd131072, 24'd16, 24'd16, 24'd16);
    idle_en = 1'b0;
    send_random(110);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------

  initial begin
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk_i);
      end else if (idle_en && $urandom_range(0, 6) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(0, 10)) @(negedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    voxel_reply_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reply_q.size() == 0) begin
        $error("unexpected result word: is_free=%0b marked=%0b", is_free_o, marked_o);
        n_errors++;
      end else begin
        want = reply_q.pop_front();
        if (is_free_o !== want.is_free) begin
          $error("is_free mismatch: expected %0b, actual %0b", want.is_free, is_free_o);
          n_errors++;
        end
        if (marked_o !== want.marked) begin
          $error("marked mismatch: expected %0b, actual %0b", want.marked, marked_o);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $error("no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    grid_origin  = '{default: ORIGIN_RST};
    grid_inv_res = INV_RES_RST;
    grid_size    = '{default: SIZE_RST};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_default_grid();
    test_register_corners();
    test_random_default();
    test_small_grids();
    test_random_grids();
    test_output_stall();
    test_steady_stream();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
